### rtl/bsa_pkg.sv
// Shared types, constants and helper functions for the bitmap slot allocator.
// No dependencies; imported by the controller, the datapath and the checker.
`timescale 1ns / 1ps
`default_nettype none

package bsa_pkg;

   localparam int ADDR_BITS      = 48;
   localparam int LOG2_BITS      = 5;
   localparam int LOG2_MIN       = 4;
   localparam int LOG2_MAX       = 16;
   localparam int BLOCK_BYTES    = 65536;
   localparam int OFS_BITS       = 16;
   localparam int MAX_SLOTS      = 4096;
   localparam int COUNT_BITS     = 13;
   localparam int MAP_WORD_BITS  = 64;
   localparam int MAP_WORDS      = 64;
   localparam int BIT_IDX_BITS   = 6;
   localparam int WORD_IDX_BITS  = 6;
   localparam int SLOT_IDX_BITS  = WORD_IDX_BITS + BIT_IDX_BITS;
   localparam int RSP_DATA_BITS  = 64;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SLOT_LOG2  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BLOCK_BASE = 1'b1;

   typedef enum logic [1:0] {
      ST_OK           = 2'd0,
      ST_FULL         = 2'd1,
      ST_BAD_ADDR     = 2'd2,
      ST_ALREADY_FREE = 2'd3
   } status_type;

   typedef struct packed {
      logic clear;
      logic capture;
      logic lookup;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic cfg_clear;
      logic out_free;
   } dp_status_type;

   // Index of the lowest set bit; zero when none is set.
   function automatic logic [BIT_IDX_BITS-1:0] lowest_set(input logic [MAP_WORD_BITS-1:0] v);
      logic [BIT_IDX_BITS-1:0] r;
      r = '0;
      for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            r = BIT_IDX_BITS'(i);
         end
      end
      return r;
   endfunction

   // Free bits of one map word right after a clear, for a given slot count.
   function automatic logic [MAP_WORD_BITS-1:0] fill_word(input logic [WORD_IDX_BITS-1:0] w,
                                                          input logic [COUNT_BITS-1:0] n);
      logic [COUNT_BITS:0]        lo;
      logic [COUNT_BITS:0]        n_ext;
      logic [COUNT_BITS:0]        rem;
      logic [MAP_WORD_BITS-1:0]   r;
      lo    = {(COUNT_BITS + 1 - SLOT_IDX_BITS)'(0), w, BIT_IDX_BITS'(0)};
      n_ext = {1'b0, n};
      rem   = n_ext - lo;
      if (n_ext >= lo + (COUNT_BITS + 1)'(MAP_WORD_BITS)) begin
         r = '1;
      end else if (n_ext <= lo) begin
         r = '0;
      end else begin
         r = (MAP_WORD_BITS'(1) << rem[BIT_IDX_BITS-1:0]) - MAP_WORD_BITS'(1);
      end
      return r;
   endfunction

   // One bit per map word: set where the word holds any slot.
   function automatic logic [MAP_WORDS-1:0] summary_fill(input logic [COUNT_BITS-1:0] n);
      logic [MAP_WORDS-1:0] r;
      for (int w = 0; w < MAP_WORDS; w++) begin
         r[w] = ((COUNT_BITS + 1)'(w) * (COUNT_BITS + 1)'(MAP_WORD_BITS)) < {1'b0, n};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/bsa_ctrl.sv
// Sequencing state machine of the slot allocator: clear pass, accept, lookup, commit.
// Depends on bsa_pkg; drives commands into bsa_datapath.
`timescale 1ns / 1ps
`default_nettype none

module bsa_ctrl
   import bsa_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd
);

   typedef enum logic [3:0] {
      S_CLEAR  = 4'b0001,
      S_IDLE   = 4'b0010,
      S_LOOK   = 4'b0100,
      S_COMMIT = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_tready  = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = !status.cfg_clear;
            if (req_tvalid && !status.cfg_clear) begin
               cmd.capture = 1'b1;
               state_in    = S_LOOK;
            end
         end
         S_LOOK: begin
            cmd.lookup = 1'b1;
            state_in   = S_COMMIT;
         end
         S_COMMIT: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
      if (status.cfg_clear) begin
         state_in = S_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### rtl/bsa_datapath.sv
// Datapath of the slot allocator: config registers, free map memory, summary,
// free count, address checks and the result register. Depends on bsa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsa_datapath
   import bsa_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire ctrl_cmd_type              cmd,
   output dp_status_type                  status,
   input  wire logic                      csr_valid,
   input  wire logic                      csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [ADDR_BITS-1:0]      csr_data,
   input  wire logic                      req_op,
   input  wire logic [ADDR_BITS-1:0]      req_addr,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [RSP_DATA_BITS-1:0]       rsp_tdata,
   output logic [1:0]                     rsp_tuser
);

   logic [LOG2_BITS-1:0]     slot_log2_ff;
   logic [ADDR_BITS-1:0]     base_ff;
   logic [WORD_IDX_BITS-1:0] clr_ptr_ff;
   logic [MAP_WORDS-1:0]     summary_ff;
   logic [COUNT_BITS-1:0]    free_total_ff;
   logic [MAP_WORD_BITS-1:0] map_mem [MAP_WORDS];

   logic                     op_ff;
   logic [ADDR_BITS-1:0]     addr_ff;
   logic [WORD_IDX_BITS-1:0] widx_ff;
   logic [BIT_IDX_BITS-1:0]  rel_bit_ff;
   logic                     bad_ff;
   logic                     full_ff;
   logic [MAP_WORD_BITS-1:0] rd_word_ff;

   logic                     rsp_valid_ff;
   logic [ADDR_BITS-1:0]     rsp_addr_ff;
   status_type               rsp_status_ff;
   logic [COUNT_BITS-1:0]    rsp_free_ff;

   logic                     cfg_write;
   logic [LOG2_BITS-1:0]     lg;
   logic [OFS_BITS:0]        n_full;
   logic [COUNT_BITS-1:0]    slot_n;

   logic [ADDR_BITS:0]       end_addr;
   logic                     in_range;
   logic [ADDR_BITS-1:0]     ofs;
   logic [OFS_BITS:0]        ofs_ext;
   logic [OFS_BITS:0]        align_mask;
   logic [OFS_BITS:0]        rel_idx_full;
   logic                     bad_addr;
   logic [SLOT_IDX_BITS-1:0] rel_idx;
   logic [WORD_IDX_BITS-1:0] look_widx;

   logic [BIT_IDX_BITS-1:0]  alloc_bit;
   logic [MAP_WORD_BITS-1:0] alloc_word;
   logic [MAP_WORD_BITS-1:0] rel_mask;
   logic [MAP_WORD_BITS-1:0] rel_word;
   logic                     already_free;
   logic [SLOT_IDX_BITS+OFS_BITS-1:0] slot_ofs;
   logic [ADDR_BITS-1:0]     alloc_addr;

   logic                     wr_en;
   logic [MAP_WORD_BITS-1:0] wr_word;
   logic                     sum_bit;
   logic [COUNT_BITS-1:0]    total_in;
   logic [ADDR_BITS-1:0]     res_addr;
   status_type               res_status;

   assign cfg_write = csr_valid && csr_ready;

   always_comb begin
      if (slot_log2_ff < LOG2_BITS'(LOG2_MIN)) begin
         lg = LOG2_BITS'(LOG2_MIN);
      end else if (slot_log2_ff > LOG2_BITS'(LOG2_MAX)) begin
         lg = LOG2_BITS'(LOG2_MAX);
      end else begin
         lg = slot_log2_ff;
      end
      n_full = (OFS_BITS + 1)'(BLOCK_BYTES) >> lg;
      if (n_full > (OFS_BITS + 1)'(MAX_SLOTS)) begin
         slot_n = COUNT_BITS'(MAX_SLOTS);
      end else begin
         slot_n = n_full[COUNT_BITS-1:0];
      end
   end

   // release address checks and word select
   always_comb begin
      end_addr     = {1'b0, base_ff} + (ADDR_BITS + 1)'(BLOCK_BYTES);
      in_range     = (addr_ff >= base_ff) && ({1'b0, addr_ff} < end_addr);
      ofs          = addr_ff - base_ff;
      ofs_ext      = {1'b0, ofs[OFS_BITS-1:0]};
      align_mask   = ((OFS_BITS + 1)'(1) << lg) - (OFS_BITS + 1)'(1);
      rel_idx_full = ofs_ext >> lg;
      bad_addr     = !in_range || ((ofs_ext & align_mask) != '0)
                     || (rel_idx_full >= (OFS_BITS + 1)'(slot_n));
      rel_idx      = rel_idx_full[SLOT_IDX_BITS-1:0];
      if (op_ff == OP_ALLOC) begin
         look_widx = lowest_set(summary_ff);
      end else begin
         look_widx = rel_idx[SLOT_IDX_BITS-1:BIT_IDX_BITS];
      end
   end

   // word update and result
   always_comb begin
      alloc_bit    = lowest_set(rd_word_ff);
      alloc_word   = rd_word_ff & ~(MAP_WORD_BITS'(1) << alloc_bit);
      rel_mask     = MAP_WORD_BITS'(1) << rel_bit_ff;
      rel_word     = rd_word_ff | rel_mask;
      already_free = (rd_word_ff & rel_mask) != '0;
      slot_ofs     = (SLOT_IDX_BITS + OFS_BITS)'({widx_ff, alloc_bit}) << lg;
      alloc_addr   = base_ff + ADDR_BITS'(slot_ofs);

      wr_en      = 1'b0;
      wr_word    = rd_word_ff;
      sum_bit    = summary_ff[widx_ff];
      total_in   = free_total_ff;
      res_addr   = '0;
      res_status = ST_OK;
      if (op_ff == OP_ALLOC) begin
         if (full_ff) begin
            res_status = ST_FULL;
         end else begin
            wr_en    = 1'b1;
            wr_word  = alloc_word;
            sum_bit  = alloc_word != '0;
            total_in = free_total_ff - COUNT_BITS'(1);
            res_addr = alloc_addr;
         end
      end else begin
         if (bad_ff) begin
            res_status = ST_BAD_ADDR;
         end else if (already_free) begin
            res_status = ST_ALREADY_FREE;
         end else begin
            wr_en    = 1'b1;
            wr_word  = rel_word;
            sum_bit  = 1'b1;
            total_in = free_total_ff + COUNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_log2_ff <= LOG2_BITS'(LOG2_MIN);
         base_ff      <= '0;
         clr_ptr_ff   <= '0;
      end else begin
         if (cfg_write && (csr_index == CSR_SLOT_LOG2)) begin
            slot_log2_ff <= csr_data[LOG2_BITS-1:0];
         end
         if (cfg_write && (csr_index == CSR_BLOCK_BASE)) begin
            base_ff <= csr_data;
         end
         if (status.cfg_clear) begin
            clr_ptr_ff <= '0;
         end else if (cmd.clear) begin
            clr_ptr_ff <= clr_ptr_ff + WORD_IDX_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         map_mem[clr_ptr_ff] <= fill_word(clr_ptr_ff, slot_n);
      end else if (cmd.commit && wr_en) begin
         map_mem[widx_ff] <= wr_word;
      end
      if (cmd.lookup) begin
         rd_word_ff <= map_mem[look_widx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         summary_ff    <= summary_fill(slot_n);
         free_total_ff <= slot_n;
      end else if (cmd.commit) begin
         summary_ff[widx_ff] <= sum_bit;
         free_total_ff       <= total_in;
      end
      if (cmd.capture) begin
         op_ff   <= req_op;
         addr_ff <= req_addr;
      end
      if (cmd.lookup) begin
         widx_ff    <= look_widx;
         rel_bit_ff <= rel_idx[BIT_IDX_BITS-1:0];
         bad_ff     <= bad_addr;
         full_ff    <= free_total_ff == '0;
      end
      if (cmd.commit) begin
         rsp_addr_ff   <= res_addr;
         rsp_status_ff <= res_status;
         rsp_free_ff   <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign status.clear_last = clr_ptr_ff == WORD_IDX_BITS'(MAP_WORDS - 1);
   assign status.cfg_clear  = cfg_write && (csr_index == CSR_SLOT_LOG2);
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_BITS - ADDR_BITS - COUNT_BITS)'(0), rsp_free_ff, rsp_addr_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

`default_nettype wire

### rtl/bitmap_slot_allocator_unit.sv
// Bitmap slot allocator: a 64 KiB block cut into power-of-two slots.
// Channels: req_ (operation in tuser, release address in tdata), rsp_ (slot
// address and free count in tdata, status in tuser), csr_ register writes.
// A request is taken only from the idle state; the free map word it needs is
// read in the lookup state and written back in the commit state, which also
// loads the result register; no new request is taken until that commit, a limit
// set by the read-modify-write of one free map word in the single-port memory.
// The lowest free slot is found through a per-word summary, so allocation
// never scans the map. After reset, and after each write of the slot size,
// a clearing pass refills all 64 map words; requests wait, register
// writes are still taken. A stalled result stays in the output register; one
// more request can be taken and looked up, then the block waits for rsp_tready.
// Depends on bsa_pkg, bsa_ctrl and bsa_datapath.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_slot_allocator_unit
   import bsa_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [ADDR_BITS-1:0]      req_tdata,   // [47:0] release_address
   input  wire logic                      req_tuser,   // [0] operation
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [RSP_DATA_BITS-1:0]       rsp_tdata,   // [47:0] slot_address, [60:48] free_slots
   output logic [1:0]                     rsp_tuser,   // [1:0] status
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [ADDR_BITS-1:0]      csr_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   bsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bsa_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_op     (req_tuser),
      .req_addr   (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

### rtl/bsa_checker.sv
// Port-level checks for the bitmap slot allocator, bound to the top level.
// Depends on bsa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsa_checker
   import bsa_pkg::*;
(
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_tready,
   input wire logic                      rsp_tvalid,
   input wire logic                      rsp_tready,
   input wire logic [RSP_DATA_BITS-1:0]  rsp_tdata,
   input wire logic [1:0]                rsp_tuser,
   input wire logic                      csr_valid,
   input wire logic                      csr_ready,
   input wire logic [CSR_INDEX_BITS-1:0] csr_index
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response word changed");

   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_OK) |-> rsp_tdata[ADDR_BITS-1:0] == '0)
      else $error("failed request returned a slot address");

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[ADDR_BITS+COUNT_BITS-1:ADDR_BITS] <= COUNT_BITS'(MAX_SLOTS))
      else $error("free count above slot limit");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request taken during clearing pass");

   a_cfg_clear: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready && (csr_index == CSR_SLOT_LOG2) |=> !req_tready)
      else $error("request taken right after slot size write");

endmodule

bind bitmap_slot_allocator_unit bsa_checker u_bsa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready),
   .csr_index  (csr_index)
);

`default_nettype wire

### tb/tb_bitmap_slot_allocator_unit.sv
// Self-checking bench for bitmap_slot_allocator_unit: a directed table, then random
// allocate/release traffic under many slot sizes and base addresses, checked word by word.
// Depends on bsa_pkg (types, codes, widths) and the allocator RTL.
`timescale 1ns / 1ps

module tb_bitmap_slot_allocator_unit;
   import bsa_pkg::*;

   localparam int HALF_PERIOD = 2;
   localparam int RESET_CYCLES = 8;
   localparam int IDLE_SETTLE = 8;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int PHASES = 12;
   localparam int PHASE_ITEMS = 120;

   typedef struct packed {
      logic [ADDR_BITS-1:0]  slot_addr;
      status_type            status;
      logic [COUNT_BITS-1:0] free_slots;
   } alloc_result_type;

   typedef struct packed {
      bit                        is_csr;
      logic [CSR_INDEX_BITS-1:0] index;
      logic [ADDR_BITS-1:0]      value;
      logic                      op;
      bit                        typed;
      logic [ADDR_BITS-1:0]      want_addr;
      status_type                want_st;
      logic [COUNT_BITS-1:0]     want_free;
   } dir_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [ADDR_BITS-1:0]      req_tdata = '0;   // [47:0] release_address
   logic                      req_tuser = 1'b0; // [0] operation
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;        // [47:0] slot_address, [60:48] free_slots
   logic [1:0]                rsp_tuser;        // [1:0] status
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [ADDR_BITS-1:0]      csr_data = '0;

   // allocator image
   bit                   model_free [MAX_SLOTS];
   int unsigned          model_total;
   logic [LOG2_BITS-1:0] model_log2;
   logic [ADDR_BITS-1:0] model_base;

   alloc_result_type pending_results[$];
   dir_row_type      dir_rows[$];
   int            fail_count = 0;
   int            cycle_count = 0;
   int            req_count = 0;
   int            csr_count = 0;
   int            status_hits [4];
   int            rsp_hold = 0;
   bit            idle_on = 1'b1;
   bit            req_held = 1'b0;

   bitmap_slot_allocator_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   function automatic int pick_gap();
      int r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int unsigned eff_log2();
      int unsigned v;
      v = model_log2;
      if (v < LOG2_MIN) v = LOG2_MIN;
      if (v > LOG2_MAX) v = LOG2_MAX;
      return v;
   endfunction

   function automatic int unsigned slot_limit();
      int unsigned n;
      n = BLOCK_BYTES >> eff_log2();
      if (n > MAX_SLOTS) n = MAX_SLOTS;
      return n;
   endfunction

   function automatic void refill_free_map();
      int unsigned n;
      n = slot_limit();
      for (int i = 0; i < MAX_SLOTS; i++) model_free[i] = (i < n);
      model_total = n;
   endfunction

   function automatic alloc_result_type predict_slot_op(input logic op,
                                                        input logic [ADDR_BITS-1:0] addr);
      alloc_result_type r;
      int unsigned   lg;
      int unsigned   n;
      int unsigned   idx;
      bit            found;
      logic [63:0]   a;
      logic [63:0]   base64;
      logic [63:0]   ofs;
      r.slot_addr = '0;
      r.status = ST_OK;
      lg = eff_log2();
      n = slot_limit();
      found = 1'b0;
      idx = 0;
      if (op == OP_ALLOC) begin
         if (model_total != 0) begin
            for (int i = 0; i < n && !found; i++) begin
               if (model_free[i]) begin
                  found = 1'b1;
                  idx = i;
               end
            end
         end
         if (found) begin
            model_free[idx] = 1'b0;
            model_total--;
            r.slot_addr = ADDR_BITS'(64'(model_base) + (64'(idx) << lg));
         end else begin
            r.status = ST_FULL;
         end
      end else begin
         a = 64'(addr);
         base64 = 64'(model_base);
         if (a < base64 || a >= base64 + 64'(BLOCK_BYTES)) begin
            r.status = ST_BAD_ADDR;
         end else begin
            ofs = a - base64;
            if ((ofs & ((64'd1 << lg) - 64'd1)) != 0 || (ofs >> lg) >= 64'(n)) begin
               r.status = ST_BAD_ADDR;
            end else begin
               idx = int'(ofs >> lg);
               if (model_free[idx]) begin
                  r.status = ST_ALREADY_FREE;
               end else begin
                  model_free[idx] = 1'b1;
                  model_total++;
               end
            end
         end
      end
      r.free_slots = COUNT_BITS'(model_total);
      return r;
   endfunction

   // drop valid, let every pending word come back, then let the pipe settle
   task automatic wait_idle();
      if (req_held) begin
         req_tvalid <= 1'b0;
         req_held = 1'b0;
      end
      while (pending_results.size() != 0) @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [ADDR_BITS-1:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_SLOT_LOG2) begin
         model_log2 = value[LOG2_BITS-1:0];
         refill_free_map();
      end else begin
         model_base = value;
      end
      csr_count++;
   endtask

   task automatic send_req(input logic op, input logic [ADDR_BITS-1:0] addr,
                           input bit typed, input alloc_result_type want);
      int               g;
      alloc_result_type pred;
      g = pick_gap();
      if (g > 0) begin
         if (req_held) req_tvalid <= 1'b0;
         req_held = 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= addr;
      req_held = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pred = predict_slot_op(op, addr);
      pending_results.push_back(typed ? want : pred);
      status_hits[pred.status]++;
      req_count++;
   endtask

   task automatic add_csr(input logic [CSR_INDEX_BITS-1:0] idx, input logic [ADDR_BITS-1:0] v);
      dir_row_type r;
      r = '0;
      r.is_csr = 1'b1;
      r.index = idx;
      r.value = v;
      dir_rows.push_back(r);
   endtask

   task automatic add_op(input logic op, input logic [ADDR_BITS-1:0] addr);
      dir_row_type r;
      r = '0;
      r.op = op;
      r.value = addr;
      dir_rows.push_back(r);
   endtask

   task automatic add_chk(input logic op, input logic [ADDR_BITS-1:0] addr,
                          input logic [ADDR_BITS-1:0] waddr, input status_type st,
                          input logic [COUNT_BITS-1:0] wfree);
      dir_row_type r;
      r = '0;
      r.op = op;
      r.value = addr;
      r.typed = 1'b1;
      r.want_addr = waddr;
      r.want_st = st;
      r.want_free = wfree;
      dir_rows.push_back(r);
   endtask

   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 2) == 0) begin
         rsp_hold <= pick_gap();
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : rsp_check
      alloc_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: word with no request pending: tdata %h tuser %0d",
                     $time, rsp_tdata, rsp_tuser);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[ADDR_BITS-1:0] !== want.slot_addr) begin
               $display("%0t: slot_address expected %h actual %h",
                        $time, want.slot_addr, rsp_tdata[ADDR_BITS-1:0]);
               fail_count++;
            end
            if (rsp_tdata[ADDR_BITS+COUNT_BITS-1:ADDR_BITS] !== want.free_slots) begin
               $display("%0t: free_slots expected %0d actual %0d",
                        $time, want.free_slots, rsp_tdata[ADDR_BITS+COUNT_BITS-1:ADDR_BITS]);
               fail_count++;
            end
            if (rsp_tuser !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_tuser);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d words still pending", $time, pending_results.size());
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin : stimulus
      dir_row_type          row;
      alloc_result_type     want;
      logic [LOG2_BITS-1:0] lg_val;
      logic [ADDR_BITS-1:0] base_val;
      logic [63:0]          rnd64;
      logic [63:0]          addr64;
      int unsigned          lg;
      int unsigned          n;
      int unsigned          idx;
      int                   alloc_pct;
      int                   pick;

      for (int i = 0; i < 4; i++) status_hits[i] = 0;
      model_log2 = LOG2_BITS'(LOG2_MIN);
      model_base = '0;
      refill_free_map();

      add_chk(OP_ALLOC,   48'h0,              48'h0,              ST_OK,           13'd4095);
      add_chk(OP_ALLOC,   48'hFFFF_FFFF_FFFF, 48'h10,             ST_OK,           13'd4094);
      add_chk(OP_RELEASE, 48'h10,             48'h0,              ST_OK,           13'd4095);
      add_chk(OP_RELEASE, 48'h10,             48'h0,              ST_ALREADY_FREE, 13'd4095);
      add_chk(OP_RELEASE, 48'h8,              48'h0,              ST_BAD_ADDR,     13'd4095);
      add_chk(OP_RELEASE, 48'h1_0000,         48'h0,              ST_BAD_ADDR,     13'd4095);
      add_chk(OP_RELEASE, 48'hFFFF_FFFF_FFFF, 48'h0,              ST_BAD_ADDR,     13'd4095);
      add_chk(OP_RELEASE, 48'h0,              48'h0,              ST_OK,           13'd4096);
      add_chk(OP_RELEASE, 48'hFFF0,           48'h0,              ST_ALREADY_FREE, 13'd4096);
      add_csr(CSR_SLOT_LOG2, 48'd16);
      add_chk(OP_ALLOC,   48'h0,              48'h0,              ST_OK,           13'd0);
      add_chk(OP_ALLOC,   48'h0,              48'h0,              ST_FULL,         13'd0);
      add_chk(OP_RELEASE, 48'h0,              48'h0,              ST_OK,           13'd1);
      add_csr(CSR_SLOT_LOG2, 48'd31);
      add_chk(OP_ALLOC,   48'h0,              48'h0,              ST_OK,           13'd0);
      add_chk(OP_RELEASE, 48'h8000,           48'h0,              ST_BAD_ADDR,     13'd0);
      add_csr(CSR_SLOT_LOG2, 48'd0);
      add_csr(CSR_BLOCK_BASE, 48'hFFFF_FFFF_0000);
      add_chk(OP_ALLOC,   48'h0,              48'hFFFF_FFFF_0000, ST_OK,           13'd4095);
      add_chk(OP_RELEASE, 48'hFFFF_FFFE_FFFF, 48'h0,              ST_BAD_ADDR,     13'd4095);
      add_chk(OP_RELEASE, 48'hFFFF_FFFF_FFF0, 48'h0,              ST_ALREADY_FREE, 13'd4095);
      // unaligned base, map kept; slot address wraps at 48 bits
      add_csr(CSR_BLOCK_BASE, 48'hFFFF_FFFF_FFF8);
      add_op(OP_ALLOC, 48'h0);
      add_op(OP_RELEASE, 48'hFFFF_FFFF_FFF8);
      add_op(OP_RELEASE, 48'h8);
      add_csr(CSR_SLOT_LOG2, 48'd5);
      add_csr(CSR_BLOCK_BASE, 48'h1234_0000);
      add_op(OP_ALLOC, 48'h0);
      add_op(OP_RELEASE, 48'h1234_0020);
      add_op(OP_RELEASE, 48'h1234_0000);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         if (row.is_csr) begin
            csr_write(row.index, row.value);
         end else begin
            want.slot_addr = row.want_addr;
            want.status = row.want_st;
            want.free_slots = row.want_free;
            send_req(row.op, row.value, row.typed, want);
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         idle_on = (ph % 4 != 3);
         rnd64 = {$urandom, $urandom};
         case (ph)
            0: begin
               lg_val = LOG2_BITS'(LOG2_MIN);
               base_val = '0;
            end
            1: begin
               lg_val = LOG2_BITS'(LOG2_MAX);
               base_val = 48'hFFFF_FFFF_0000;
            end
            default: begin
               if ($urandom_range(0, 4) == 0) lg_val = LOG2_BITS'($urandom_range(0, 31));
               else lg_val = LOG2_BITS'($urandom_range(9, 16));
               base_val = rnd64[ADDR_BITS-1:0];
               if ($urandom_range(0, 4) != 0) base_val[OFS_BITS-1:0] = '0;
            end
         endcase
         if ($urandom_range(0, 1) == 1) begin
            csr_write(CSR_BLOCK_BASE, base_val);
            csr_write(CSR_SLOT_LOG2, ADDR_BITS'(lg_val));
         end else begin
            csr_write(CSR_SLOT_LOG2, ADDR_BITS'(lg_val));
            csr_write(CSR_BLOCK_BASE, base_val);
         end
         alloc_pct = $urandom_range(30, 85);

         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (idle_on && $urandom_range(0, 149) == 0) wait_idle();
            lg = eff_log2();
            n = slot_limit();
            rnd64 = {$urandom, $urandom};
            if ($urandom_range(0, 99) < alloc_pct) begin
               send_req(OP_ALLOC, rnd64[ADDR_BITS-1:0], 1'b0, '0);
            end else begin
               pick = $urandom_range(0, 99);
               idx = $urandom_range(0, n - 1);
               if (pick < 55) begin
                  // steer toward a slot in use
                  for (int s = 0; s < n && model_free[idx]; s++) idx = (idx + 1) % n;
               end
               addr64 = 64'(model_base) + (64'(idx) << lg);
               if (pick >= 70 && pick < 80) begin
                  addr64 = addr64 + 64'($urandom_range(1, (1 << lg) - 1));
               end else if (pick >= 80 && pick < 85) begin
                  addr64 = 64'(model_base) - 64'd1;
               end else if (pick >= 85 && pick < 90) begin
                  addr64 = 64'(model_base) + 64'(BLOCK_BYTES) + 64'($urandom_range(0, 300));
               end else if (pick >= 90) begin
                  addr64 = rnd64;
               end
               send_req(OP_RELEASE, addr64[ADDR_BITS-1:0], 1'b0, '0);
            end
         end
      end

      wait_idle();
      $display("Ran %0d requests across %0d register writes, slot sizes and bases varied.",
               req_count, csr_count);
      $display("Outcomes: %0d ok, %0d full, %0d bad address, %0d already free.",
               status_hits[ST_OK], status_hits[ST_FULL], status_hits[ST_BAD_ADDR],
               status_hits[ST_ALREADY_FREE]);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
